// ----- rtl/core/pcm2d_pkg.sv -----
`default_nettype none
package pcm2d_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned FracW = 127;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_WIDTH_CODE       = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_MSB_FIRST        = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_UNSIGNED_SAMPLES = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_FLOAT_SAMPLES    = 2'd3;

    // width codes
    localparam logic [1:0] WC_1B = 2'd0;
    localparam logic [1:0] WC_2B = 2'd1;
    localparam logic [1:0] WC_4B = 2'd2;
    localparam logic [1:0] WC_8B = 2'd3;

    typedef enum logic [1:0] {
        K_DIRECT = 2'd0,
        K_INT    = 2'd1,
        K_FSUB   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic         sign;
        logic         err;
        logic [63:0]  direct;
        logic         intb;   // integer bit of the quotient
        logic [30:0]  r;      // repeating block, or float subnormal mantissa
        logic [1:0]   wc;
        logic [5:0]   lz;     // normalizing shift
    } t_mid;

    // leading zero count, 32 for zero
    function automatic logic [5:0] clz32(input logic [31:0] x);
        logic [5:0] c;
        c = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) c = 6'(31 - i);
        end
        return c;
    endfunction

    // fraction of r/(2^n-1): the n-bit block r repeated below the binary point
    function automatic logic [FracW-1:0] rep_frac(input logic [30:0] r, input logic [1:0] wc);
        logic [FracW-1:0] f;
        f = '0;
        for (int j = 0; j < FracW; j++) begin
            case (wc)
                WC_1B:   f[FracW-1-j] = r[6 - (j % 7)];
                WC_2B:   f[FracW-1-j] = r[14 - (j % 15)];
                default: f[FracW-1-j] = r[30 - (j % 31)];
            endcase
        end
        return f;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pcm2d_if.sv -----
`default_nettype none
interface pcm2d_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_bytes;
    modport source (output valid, output raw_bytes, input ready);
    modport sink   (input valid, input raw_bytes, output ready);
endinterface

interface pcm2d_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic        format_error;
    modport source (output valid, output value_bits, output format_error, input ready);
    modport sink   (input valid, input value_bits, input format_error, output ready);
endinterface

interface pcm2d_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pcm_sample_to_double.sv -----
// The input, mid and output registers lie between the input transfer and the result.
// Throughput: one sample per cycle while the output is ready; each stage advances when the next one is free.
// The critical stage is the 128-bit normalizing shift and rounding add.
// Reset (synchronous, active low) empties the pipeline and sets 2-byte
// signed little-endian integer format.
`default_nettype none
module pcm_sample_to_double (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pcm2d_cfg_if.sink i_cfg,
    pcm2d_in_if.sink  i_in,
    pcm2d_out_if.source o_out
);
    logic [1:0]  r_wc;
    logic        r_big, r_uns, r_flt;
    logic        r_v0, r_v1, r_v2;
    logic [63:0] r_raw;
    pcm2d_pkg::t_mid r_mid, n_mid;
    logic [63:0] r_bits, n_bits;
    logic        r_err, n_err;
    logic        rdy0, rdy1, rdy2;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc  <= pcm2d_pkg::WC_2B;
            r_big <= 1'b0;
            r_uns <= 1'b0;
            r_flt <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pcm2d_pkg::REG_WIDTH_CODE:       r_wc  <= i_cfg.data[1:0];
                pcm2d_pkg::REG_MSB_FIRST:        r_big <= i_cfg.data[0];
                pcm2d_pkg::REG_UNSIGNED_SAMPLES: r_uns <= i_cfg.data[0];
                pcm2d_pkg::REG_FLOAT_SAMPLES:    r_flt <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign rdy2 = !r_v2 || o_out.ready;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;
    assign i_in.ready = rdy0;

    pcm2d_unpack u_unpack (
        .i_raw (r_raw),
        .i_wc  (r_wc),
        .i_big (r_big),
        .i_uns (r_uns),
        .i_flt (r_flt),
        .o_mid (n_mid)
    );

    pcm2d_pack u_pack (
        .i_mid  (r_mid),
        .o_bits (n_bits),
        .o_err  (n_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_in.valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in.valid) r_raw <= i_in.raw_bytes;
        if (rdy1 && r_v0) r_mid <= n_mid;
        if (rdy2 && r_v1) begin
            r_bits <= n_bits;
            r_err  <= n_err;
        end
    end

    assign o_out.valid        = r_v2;
    assign o_out.value_bits   = r_bits;
    assign o_out.format_error = r_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_err |-> r_bits == 64'd0)
        else $error("format error with nonzero value");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("input stalled while output drains");

    a_mid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !rdy1 |=> r_v1 && $stable(r_mid))
        else $error("mid stage lost while stalled");

    a_out_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && rdy2 |=> r_v2)
        else $error("mid item not moved to output");
endmodule
`default_nettype wire

// ----- rtl/core/pcm2d_unpack.sv -----
`default_nettype none
module pcm2d_unpack (
    input  wire logic [63:0]    i_raw,
    input  wire logic [1:0]     i_wc,
    input  wire logic           i_big,
    input  wire logic           i_uns,
    input  wire logic           i_flt,
    output pcm2d_pkg::t_mid     o_mid
);
    logic [15:0] ord2;
    logic [31:0] ord4;
    logic [63:0] ord8;
    logic [7:0]  b1;
    logic [15:0] b2;
    logic [31:0] b4;
    logic [32:0] sx;
    logic [32:0] mag;
    logic [32:0] maxv;
    logic [31:0] ta;
    logic [5:0]  clz;
    logic [7:0]  fe;
    logic [22:0] fm;

    always_comb begin
        ord2 = i_big ? {i_raw[7:0], i_raw[15:8]} : i_raw[15:0];
        ord4 = i_big ? {i_raw[7:0], i_raw[15:8], i_raw[23:16], i_raw[31:24]} : i_raw[31:0];
        for (int i = 0; i < 8; i++) begin
            ord8[8*i +: 8] = i_big ? i_raw[8*(7-i) +: 8] : i_raw[8*i +: 8];
        end
    end

    always_comb begin
        b1 = i_raw[7:0] ^ {i_uns, 7'b0};
        b2 = ord2 ^ {i_uns, 15'b0};
        b4 = ord4 ^ {i_uns, 31'b0};
        case (i_wc)
            pcm2d_pkg::WC_1B: begin
                sx = {{25{b1[7]}}, b1};
                maxv = 33'd127;
            end
            pcm2d_pkg::WC_2B: begin
                sx = {{17{b2[15]}}, b2};
                maxv = 33'd32767;
            end
            default: begin
                sx = {b4[31], b4};
                maxv = 33'h07FFFFFFF;
            end
        endcase
        mag = sx[32] ? 33'(~sx + 33'd1) : sx;
    end

    assign fe = ord4[30:23];
    assign fm = ord4[22:0];

    always_comb begin
        if (i_flt) begin
            ta = {fm, 9'b0};
        end else begin
            case (i_wc)
                pcm2d_pkg::WC_1B: ta = {mag[6:0], 25'b0};
                pcm2d_pkg::WC_2B: ta = {mag[14:0], 17'b0};
                default:          ta = {mag[30:0], 1'b0};
            endcase
        end
        clz = pcm2d_pkg::clz32(ta);
    end

    always_comb begin
        o_mid = '0;
        o_mid.kind = pcm2d_pkg::K_DIRECT;
        o_mid.wc = i_wc;
        if (i_flt) begin
            o_mid.sign = ord4[31];
            case (i_wc)
                pcm2d_pkg::WC_8B: o_mid.direct = ord8;
                pcm2d_pkg::WC_4B: begin
                    if (fe == 8'hFF) begin
                        // NaN payload moves to the top of the fraction, quiet bit forced
                        o_mid.direct = (fm == 23'd0) ? {ord4[31], 11'h7FF, 52'd0}
                                                     : {ord4[31], 11'h7FF, 1'b1, fm[21:0], 29'd0};
                    end else if (fe == 8'd0) begin
                        if (fm == 23'd0) begin
                            o_mid.direct = {ord4[31], 63'd0};
                        end else begin
                            o_mid.kind = pcm2d_pkg::K_FSUB;
                            o_mid.r = {8'd0, fm};
                            o_mid.lz = 6'(clz + 6'd1);
                        end
                    end else begin
                        o_mid.direct = {ord4[31], 11'({3'b0, fe} + 11'd896), fm, 29'd0};
                    end
                end
                default: o_mid.err = 1'b1;
            endcase
        end else if (i_wc == pcm2d_pkg::WC_8B) begin
            o_mid.err = 1'b1;
        end else if (mag != 33'd0) begin
            o_mid.kind = pcm2d_pkg::K_INT;
            o_mid.sign = sx[32];
            if (mag == maxv) begin
                o_mid.intb = 1'b1;
            end else if (mag == 33'(maxv + 33'd1)) begin
                // most negative code: 1 + 1/max
                o_mid.intb = 1'b1;
                o_mid.r = 31'd1;
            end else begin
                o_mid.r = mag[30:0];
                o_mid.lz = 6'(clz + 6'd1);
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/pcm2d_pack.sv -----
`default_nettype none
module pcm2d_pack (
    input  wire pcm2d_pkg::t_mid i_mid,
    output logic [63:0]     o_bits,
    output logic            o_err
);
    logic [127:0] w;
    logic [127:0] sh;
    logic [23:0]  mm;
    logic [10:0]  ex;

    always_comb begin
        w = {i_mid.intb, pcm2d_pkg::rep_frac(i_mid.r, i_mid.wc)};
        sh = w << i_mid.lz;
        mm = 24'(i_mid.r[22:0]) << i_mid.lz;
        ex = 11'd0;
        case (i_mid.kind)
            pcm2d_pkg::K_INT: begin
                ex = 11'(11'd1023 - {5'd0, i_mid.lz});
                // block repeats forever when nonzero, so no ties: round bit decides
                o_bits = 64'({i_mid.sign, ex, sh[126:75]} + 64'(sh[74]));
            end
            pcm2d_pkg::K_FSUB: begin
                ex = 11'(11'd897 - {5'd0, i_mid.lz});
                o_bits = {i_mid.sign, ex, mm[22:0], 29'd0};
            end
            default: o_bits = i_mid.direct;
        endcase
        o_err = i_mid.err;
        if (i_mid.err) o_bits = 64'd0;
    end
endmodule
`default_nettype wire

// ----- dv/tb_pcm_sample_to_double.sv -----
`default_nettype none
module tb_pcm_sample_to_double;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] value_bits;
        logic        format_error;
    } t_sample_out;

    class sample_scoreboard;
        logic [1:0]  width_code = pcm2d_pkg::WC_2B;
        logic        msb_first = 1'b0;
        logic        unsigned_samples = 1'b0;
        logic        float_samples = 1'b0;
        t_sample_out pending[$];
        int          n_errors = 0;

        function void set_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                pcm2d_pkg::REG_WIDTH_CODE:       width_code = data[1:0];
                pcm2d_pkg::REG_MSB_FIRST:        msb_first = data[0];
                pcm2d_pkg::REG_UNSIGNED_SAMPLES: unsigned_samples = data[0];
                pcm2d_pkg::REG_FLOAT_SAMPLES:    float_samples = data[0];
                default: ;
            endcase
        endfunction

        function logic [63:0] arrange(logic [63:0] raw, int nbytes);
            logic [63:0] v;
            v = '0;
            for (int i = 0; i < nbytes; i++) begin
                if (msb_first) v[8*(nbytes-1-i) +: 8] = raw[8*i +: 8];
                else           v[8*i +: 8] = raw[8*i +: 8];
            end
            return v;
        endfunction

        // exact binary32 -> binary64
        function logic [63:0] widen(logic [31:0] f);
            logic [7:0]  e;
            logic [22:0] m;
            logic [10:0] de;
            int          k;
            e = f[30:23];
            m = f[22:0];
            if (e == 8'hFF) begin
                if (m == 0) return {f[31], 11'h7FF, 52'h0};
                return {f[31], 11'h7FF, 1'b1, m[21:0], 29'h0};
            end
            if (e == 0) begin
                if (m == 0) return {f[31], 63'h0};
                k = 0;
                while (!m[22]) begin
                    m = m << 1;
                    k++;
                end
                // one more shift drops the hidden bit
                m = m << 1;
                de = 11'(1023 - 127 - k);
                return {f[31], de, m, 29'h0};
            end
            de = 11'(e) + 11'd896;
            return {f[31], de, m, 29'h0};
        endfunction

        function void note_input(logic [63:0] raw);
            t_sample_out r;
            logic [63:0] v;
            int          s8;
            longint      s;
            r.value_bits = '0;
            r.format_error = 1'b0;
            case (width_code)
                pcm2d_pkg::WC_1B: begin
                    if (float_samples) r.format_error = 1'b1;
                    else begin
                        s8 = $signed(raw[7:0] ^ {unsigned_samples, 7'h0});
                        r.value_bits = $realtobits(real'(s8) / 127.0);
                    end
                end
                pcm2d_pkg::WC_2B: begin
                    if (float_samples) r.format_error = 1'b1;
                    else begin
                        v = arrange(raw, 2);
                        s = $signed(v[15:0] ^ {unsigned_samples, 15'h0});
                        r.value_bits = $realtobits(real'(s) / 32767.0);
                    end
                end
                pcm2d_pkg::WC_4B: begin
                    v = arrange(raw, 4);
                    if (float_samples) r.value_bits = widen(v[31:0]);
                    else begin
                        s = $signed(v[31:0] ^ {unsigned_samples, 31'h0});
                        r.value_bits = $realtobits(real'(s) / 2147483647.0);
                    end
                end
                default: begin
                    if (float_samples) r.value_bits = arrange(raw, 8);
                    else r.format_error = 1'b1;
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [63:0] bits, logic err);
            t_sample_out x;
            if (pending.size() == 0) begin
                $error("unexpected result value_bits=%h format_error=%b", bits, err);
                n_errors++;
                return;
            end
            x = pending.pop_front();
            if (bits !== x.value_bits) begin
                $error("value_bits: expected %h, actual %h", x.value_bits, bits);
                n_errors++;
            end
            if (err !== x.format_error) begin
                $error("format_error: expected %b, actual %b", x.format_error, err);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   max_gap = 10;
    int   max_stall = 10;
    int   idle_cycles = 0;
    int   n_results = 0;
    bit   watchdog_fired = 1'b0;
    sample_scoreboard sb = new();

    pcm2d_cfg_if cfg_if();
    pcm2d_in_if  in_if();
    pcm2d_out_if out_if();

    pcm_sample_to_double u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        in_if.valid = 1'b0;
        in_if.raw_bytes = '0;
        out_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.value_bits, out_if.format_error);
            n_results++;
        end
    end

    // result side: random stalls, one long hold-off to back the pipe up
    initial begin
        int stall;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!long_hold_done && n_results >= 300) begin
                stall = 200;
                long_hold_done = 1'b1;
            end else begin
                stall = $urandom_range(0, max_stall);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= 3000 && !watchdog_fired) begin
            watchdog_fired = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_format(logic [1:0] wc, logic be, logic us, logic fl);
        logic [7:0] vals[4];
        logic [1:0] idx[4];
        idx = '{pcm2d_pkg::REG_WIDTH_CODE, pcm2d_pkg::REG_MSB_FIRST,
                pcm2d_pkg::REG_UNSIGNED_SAMPLES, pcm2d_pkg::REG_FLOAT_SAMPLES};
        vals[0] = {6'($urandom), wc};
        vals[1] = {7'($urandom), be};
        vals[2] = {7'($urandom), us};
        vals[3] = {7'($urandom), fl};
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data <= vals[i];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_sample(logic [63:0] raw);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.raw_bytes <= raw;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(raw);
    endtask

    function automatic logic [63:0] random_sample();
        logic [63:0] raw;
        logic [63:0] edges[8];
        edges = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h80, 64'h8000, 64'h8000_0000,
                  64'h7F, 64'h7FFF, 64'h7FFF_FFFF};
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: raw[31:0] = edges[$urandom_range(0, 7)][31:0];
            1: raw[31:0] = {raw[31], 8'hFF, raw[22:0]};
            2: raw[31:0] = {raw[31], 8'h00, raw[22:0] >> $urandom_range(0, 22)};
            3: raw[31:0] = {raw[7:0], raw[31], 8'hFF, raw[22:8]};
            default: ;
        endcase
        return raw;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset format: 2-byte signed little endian
        send_sample(64'h8000);
        send_sample(64'h7FFF);
        send_sample(64'h0);
        send_sample(64'hFFFF_FFFF_FFFF_8001);
        write_format(pcm2d_pkg::WC_4B, 1'b0, 1'b1, 1'b1);
        send_sample(64'h7F80_0000);
        send_sample(64'hFF80_0001);
        send_sample(64'h0000_0001);
        send_sample(64'h8040_0000);
        send_sample(64'h7FC0_0000);
        send_sample(64'h8000_0000);
        send_sample(64'h007F_FFFF);
        write_format(pcm2d_pkg::WC_1B, 1'b1, 1'b0, 1'b1);
        send_sample(64'h7F);
        write_format(pcm2d_pkg::WC_8B, 1'b0, 1'b0, 1'b0);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF);
        write_format(pcm2d_pkg::WC_8B, 1'b1, 1'b0, 1'b1);
        send_sample(64'h0123_4567_89AB_CDEF);
        write_format(pcm2d_pkg::WC_1B, 1'b1, 1'b1, 1'b0);
        send_sample(64'h0);
        send_sample(64'hFF);
        send_sample(64'h80);
        write_format(pcm2d_pkg::WC_4B, 1'b1, 1'b0, 1'b0);
        send_sample(64'h0000_0080);
        send_sample(64'hFFFF_FF7F);

        // every format combination, twice over
        for (int pass = 0; pass < 2; pass++) begin
            for (int c = 0; c < 32; c++) begin
                write_format(c[1:0], c[2], c[3], c[4]);
                max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
                max_stall = ($urandom_range(0, 3) == 0) ? 0 : 10;
                for (int n = 0; n < 22; n++) send_sample(random_sample());
            end
        end
        in_if.valid <= 1'b0;
        max_stall = 10;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
